// ===== sv/lcdns_pkg.sv =====
package lcdns_pkg;

	localparam int unsigned INIT_BYTES = 6;
	localparam int unsigned BYTE_IDX_W = $clog2(INIT_BYTES);

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_RAW    = 3'd1,
		OP_DATA   = 3'd2,
		OP_CURSOR = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_ENABLE_PULSE   = 2'd0,
		REG_POWER_UP       = 2'd1,
		REG_COMMAND_SETTLE = 2'd2,
		REG_CLEAR_SETTLE   = 2'd3
	} reg_idx_t;

	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] ADDR_FALLBACK = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic [7:0] enable_pulse_ms;
		logic [7:0] power_up_ms;
		logic [7:0] command_settle_ms;
		logic [7:0] clear_settle_ms;
	} cfg_regs_t;

	// request to the shared adder
	typedef struct packed {
		logic       addr_mode;
		logic [2:0] row;
		logic [4:0] column;
		logic [7:0] pulse;
		logic [7:0] settle;
	} unit_req_t;

	typedef struct packed {
		logic [8:0] sum;
	} unit_rsp_t;

	typedef struct packed {
		logic       reg_select;
		logic [3:0] nibble;
		logic       enable;
		logic [8:0] wait_ms;
		logic       last;
	} lcd_event_t;

	// DDRAM row base minus one, so that base + column - 1 is one add
	function automatic logic [7:0] row_base_m1(input logic [2:0] row);
		logic [7:0] b;
		case (row)
			3'd1:    b = 8'h7F;
			3'd2:    b = 8'hBF;
			3'd3:    b = 8'h93;
			3'd4:    b = 8'hD3;
			default: b = 8'h7F;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] init_cmd(input logic [BYTE_IDX_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h33;
			3'd1:    c = 8'h32;
			3'd2:    c = 8'h28;
			3'd3:    c = 8'h0C;
			3'd4:    c = 8'h01;
			3'd5:    c = 8'h02;
			default: c = 8'h02;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/char_lcd_nibble_sequencer.sv =====
// Flow: a taken request passes the prep state, then the emit state loads pin events into the
// output register, one event a cycle while the receiver takes them. 4 events per ordinary request;
// init gives 25 events. The sequencer uses the single shared adder and takes no request until idle.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, registers back to
// enable pulse 2, power-up 40, command settle 1, clear settle 10.
module char_lcd_nibble_sequencer
	import lcdns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // op[2:0], value[10:3], row[13:11], column[18:14]
	// pin event stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // nibble[3:0], enable[4], wait_ms[13:5]
	output logic        m_axis_tuser,  // reg_select
	output logic        m_axis_tlast,  // last event of the request
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_regs_t  cfg_q;
	unit_req_t  unit_req;
	unit_rsp_t  unit_rsp;
	lcd_event_t ev;

	// Register writes are always taken; unknown indexes fall through.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_pulse_ms   <= 8'd2;
			cfg_q.power_up_ms       <= 8'd40;
			cfg_q.command_settle_ms <= 8'd1;
			cfg_q.clear_settle_ms   <= 8'd10;
		end else if (cfg_valid && cfg_ready && !cfg_index[2]) begin
			unique case (reg_idx_t'(cfg_index[1:0]))
				REG_ENABLE_PULSE:   cfg_q.enable_pulse_ms   <= cfg_data;
				REG_POWER_UP:       cfg_q.power_up_ms       <= cfg_data;
				REG_COMMAND_SETTLE: cfg_q.command_settle_ms <= cfg_data;
				REG_CLEAR_SETTLE:   cfg_q.clear_settle_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared adder: cursor address in the prep cycle, final-event wait otherwise.
	lcdns_unit u_unit (
		.req (unit_req),
		.rsp (unit_rsp)
	);

	// Event sequencer with its output register.
	lcdns_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tdata[2:0]),
		.in_value  (s_axis_tdata[10:3]),
		.in_row    (s_axis_tdata[13:11]),
		.in_column (s_axis_tdata[18:14]),
		.cfg       (cfg_q),
		.unit_req  (unit_req),
		.unit_rsp  (unit_rsp),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_ev    (ev)
	);

	assign m_axis_tdata = {2'b00, ev.wait_ms, ev.enable, ev.nibble};
	assign m_axis_tuser = ev.reg_select;
	assign m_axis_tlast = ev.last;

	// A stalled event holds still until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled event changed");

	// Enable-high events always hold for the plain pulse time.
	a_pulse_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[13:5] == {1'b0, cfg_q.enable_pulse_ms})
		else $error("enable-high event with wrong wait");

	// Requests are not taken while one is in progress.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] <= OP_CLEAR |=> !s_axis_tready)
		else $error("request accepted while busy");

endmodule

// ===== sv/lcdns_unit.sv =====
module lcdns_unit
	import lcdns_pkg::*;
(
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic       in_range;
	logic [8:0] opa;
	logic [8:0] opb;
	logic [8:0] sum;

	assign in_range = (req.row >= 3'd1) && (req.row <= 3'd4) &&
		(req.column >= 5'd1) && (req.column <= 5'd20);

	// address mode: (base - 1) + column; wait mode: pulse + settle
	assign opa = req.addr_mode ? {1'b0, row_base_m1(req.row)} : {1'b0, req.pulse};
	assign opb = req.addr_mode ? {4'b0, req.column} : {1'b0, req.settle};
	assign sum = opa + opb;

	assign rsp.sum = (req.addr_mode && !in_range) ? {1'b0, ADDR_FALLBACK} : sum;

endmodule

// ===== sv/lcdns_seq.sv =====
module lcdns_seq
	import lcdns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] in_op,
	input  logic [7:0] in_value,
	input  logic [2:0] in_row,
	input  logic [4:0] in_column,
	input  cfg_regs_t  cfg,
	output unit_req_t  unit_req,
	input  unit_rsp_t  unit_rsp,
	output logic       out_valid,
	input  logic       out_ready,
	output lcd_event_t out_ev
);

	state_t                state_q;
	logic [2:0]            op_q;
	logic [7:0]            value_q;
	logic [2:0]            row_q;
	logic [4:0]            column_q;
	logic [7:0]            settle_q;
	logic [7:0]            byte_q;
	logic                  rs_q;
	logic                  init_q;
	logic                  lead_q;
	logic [1:0]            phase_q;
	logic [BYTE_IDX_W-1:0] byte_idx_q;
	logic                  out_valid_q;
	lcd_event_t            ev_q;

	logic       accept;
	logic       out_free;
	logic       load_ev;
	logic       op_ok;
	logic       last_ev;
	logic [7:0] prep_byte;
	logic [7:0] in_settle;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign op_ok     = (in_op <= OP_CLEAR);
	assign out_free  = !out_valid_q || out_ready;
	assign load_ev   = (state_q == ST_EMIT) && out_free;
	assign last_ev   = !lead_q && (phase_q == 2'd3) &&
		(!init_q || (byte_idx_q == BYTE_IDX_W'(INIT_BYTES - 1)));
	assign out_valid = out_valid_q;
	assign out_ev    = ev_q;

	assign unit_req.addr_mode = (state_q == ST_PREP);
	assign unit_req.row       = row_q;
	assign unit_req.column    = column_q;
	assign unit_req.pulse     = cfg.enable_pulse_ms;
	assign unit_req.settle    = settle_q;

	always_comb begin
		case (in_op)
			OP_INIT, OP_CURSOR: in_settle = cfg.command_settle_ms;
			OP_CLEAR:           in_settle = cfg.clear_settle_ms;
			default:            in_settle = 8'd0;
		endcase
	end

	always_comb begin
		unique case (op_t'(op_q))
			OP_INIT:   prep_byte = init_cmd('0);
			OP_RAW:    prep_byte = value_q;
			OP_DATA:   prep_byte = value_q;
			OP_CURSOR: prep_byte = unit_rsp.sum[7:0];
			OP_CLEAR:  prep_byte = CMD_CLEAR;
			default:   prep_byte = CMD_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			lead_q      <= 1'b0;
			phase_q     <= 2'd0;
			byte_idx_q  <= '0;
		end else begin
			if (load_ev)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op_ok)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					lead_q     <= init_q;
					phase_q    <= 2'd0;
					byte_idx_q <= '0;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_ev) begin
						if (lead_q) begin
							lead_q <= 1'b0;
						end else begin
							phase_q <= phase_q + 2'd1;
							if (phase_q == 2'd3) begin
								if (last_ev)
									state_q <= ST_IDLE;
								else
									byte_idx_q <= byte_idx_q + BYTE_IDX_W'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= in_op;
			value_q  <= in_value;
			row_q    <= in_row;
			column_q <= in_column;
			settle_q <= in_settle;
			rs_q     <= (in_op == OP_DATA);
			init_q   <= (in_op == OP_INIT);
		end
		if (state_q == ST_PREP)
			byte_q <= prep_byte;
		if (load_ev) begin
			if (lead_q) begin
				ev_q.reg_select <= 1'b0;
				ev_q.nibble     <= 4'd0;
				ev_q.enable     <= 1'b0;
				ev_q.wait_ms    <= {1'b0, cfg.power_up_ms};
				ev_q.last       <= 1'b0;
			end else begin
				ev_q.reg_select <= rs_q;
				ev_q.nibble     <= phase_q[1] ? byte_q[3:0] : byte_q[7:4];
				ev_q.enable     <= !phase_q[0];
				ev_q.wait_ms    <= (phase_q == 2'd3) ? unit_rsp.sum
					: {1'b0, cfg.enable_pulse_ms};
				ev_q.last       <= last_ev;
				if ((phase_q == 2'd3) && !last_ev)
					byte_q <= init_cmd(byte_idx_q + BYTE_IDX_W'(1));
			end
		end
	end

endmodule

// ===== dv/tb_char_lcd_nibble_sequencer.sv =====
module tb_char_lcd_nibble_sequencer
	import lcdns_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// run length and pacing
	localparam int unsigned CYCLE_LIMIT    = 1_000_000;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned RESET_CYCLES   = 12;
	localparam int unsigned PHASE_ITEMS    = 28;
	localparam int unsigned REG_COUNT      = 4;
	localparam int unsigned MAX_CFG_INDEX  = 7;
	localparam int unsigned MAX_OP_CODE    = 7;
	localparam int unsigned REPORT_LIMIT   = 10;

	// DDRAM row bases and the start-up command string
	localparam logic [7:0] ROW1_BASE = 8'h80;
	localparam logic [7:0] ROW2_BASE = 8'hC0;
	localparam logic [7:0] ROW3_BASE = 8'h94;
	localparam logic [7:0] ROW4_BASE = 8'hD4;
	localparam logic [7:0] START_SEQ [INIT_BYTES] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h01, 8'h02};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // op[2:0], value[10:3], row[13:11], column[18:14]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // nibble[3:0], enable[4], wait_ms[13:5]
	logic        m_axis_tuser;   // reg_select
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	char_lcd_nibble_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// requests waiting for the driver, pin events still owed by the block
	logic [23:0]  pending_reqs [$];
	lcd_event_t   pin_events_due [$];
	cfg_regs_t    timing_regs;       // our copy of the four timing registers

	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count    = 0;
	bit           req_xfer       = 1'b0;  // request transfer at the last rising edge
	bit           src_calm       = 1'b0;  // stretch with no sender gaps
	bit           sink_calm      = 1'b0;  // stretch with no receiver stalls
	int unsigned  src_gap        = 0;
	int unsigned  sink_gap       = 0;

	always #5 clk = ~clk;

	// -------------------------------------------------------------------------
	// pin event predictor
	// -------------------------------------------------------------------------

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [23:0] pack_req(logic [2:0] op, logic [7:0] value,
			logic [2:0] row, logic [4:0] column);
		return {5'd0, column, row, value, op};
	endfunction

	// out-of-range row or column falls back to the home address
	function automatic logic [7:0] cursor_addr(logic [2:0] row, logic [4:0] column);
		logic [7:0] base;
		if (row < 3'd1 || row > 3'd4 || column < 5'd1 || column > 5'd20)
			return ROW1_BASE;
		case (row)
			3'd1:    base = ROW1_BASE;
			3'd2:    base = ROW2_BASE;
			3'd3:    base = ROW3_BASE;
			default: base = ROW4_BASE;
		endcase
		return base + {3'd0, column} - 8'd1;
	endfunction

	function automatic void push_event(logic rs, logic [3:0] nib, logic en,
			logic [8:0] hold, logic fin);
		lcd_event_t ev;
		ev.reg_select = rs;
		ev.nibble     = nib;
		ev.enable     = en;
		ev.wait_ms    = hold;
		ev.last       = fin;
		pin_events_due.push_back(ev);
	endfunction

	// high nibble then low nibble, each an enable high/low pair; settle rides
	// on the final enable-low
	function automatic void push_byte(logic rs, logic [7:0] b, logic [7:0] settle, logic fin);
		logic [8:0] pulse;
		pulse = {1'b0, timing_regs.enable_pulse_ms};
		push_event(rs, b[7:4], 1'b1, pulse, 1'b0);
		push_event(rs, b[7:4], 1'b0, pulse, 1'b0);
		push_event(rs, b[3:0], 1'b1, pulse, 1'b0);
		push_event(rs, b[3:0], 1'b0, pulse + {1'b0, settle}, fin);
	endfunction

	function automatic void predict_request(logic [23:0] req);
		logic [2:0] op;
		logic [7:0] value;
		logic [2:0] row;
		logic [4:0] column;
		op     = req[2:0];
		value  = req[10:3];
		row    = req[13:11];
		column = req[18:14];
		case (op)
			OP_INIT: begin
				push_event(1'b0, 4'd0, 1'b0, {1'b0, timing_regs.power_up_ms}, 1'b0);
				for (int i = 0; i < INIT_BYTES; i++)
					push_byte(1'b0, START_SEQ[i], timing_regs.command_settle_ms,
						i == INIT_BYTES - 1);
			end
			OP_RAW:    push_byte(1'b0, value, 8'd0, 1'b1);
			OP_DATA:   push_byte(1'b1, value, 8'd0, 1'b1);
			OP_CURSOR: push_byte(1'b0, cursor_addr(row, column),
				timing_regs.command_settle_ms, 1'b1);
			OP_CLEAR:  push_byte(1'b0, CMD_CLEAR, timing_regs.clear_settle_ms, 1'b1);
			default:   ;  // undefined op: nothing on the pins
		endcase
	endfunction

	// unknown register indexes are dropped
	function automatic void apply_reg_write(logic [2:0] idx, logic [7:0] data);
		if (idx < REG_COUNT) begin
			case (reg_idx_t'(idx[1:0]))
				REG_ENABLE_PULSE:   timing_regs.enable_pulse_ms   = data;
				REG_POWER_UP:       timing_regs.power_up_ms       = data;
				REG_COMMAND_SETTLE: timing_regs.command_settle_ms = data;
				REG_CLEAR_SETTLE:   timing_regs.clear_settle_ms   = data;
			endcase
		end
	endfunction

	function automatic void check_event();
		lcd_event_t want;
		lcd_event_t got;
		got.reg_select = m_axis_tuser;
		got.nibble     = m_axis_tdata[3:0];
		got.enable     = m_axis_tdata[4];
		got.wait_ms    = m_axis_tdata[13:5];
		got.last       = m_axis_tlast;
		if (pin_events_due.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: unexpected pin event rs=%0d nib=%h en=%0d wait=%0d last=%0d",
					$realtime, got.reg_select, got.nibble, got.enable, got.wait_ms,
					got.last);
			return;
		end
		want = pin_events_due.pop_front();
		if (got.reg_select !== want.reg_select || got.nibble !== want.nibble ||
				got.enable !== want.enable || got.wait_ms !== want.wait_ms ||
				got.last !== want.last) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display({"%0t: pin event mismatch: exp rs=%0d nib=%h en=%0d wait=%0d last=%0d",
					" / got rs=%0d nib=%h en=%0d wait=%0d last=%0d"}, $realtime,
					want.reg_select, want.nibble, want.enable, want.wait_ms, want.last,
					got.reg_select, got.nibble, got.enable, got.wait_ms, got.last);
		end
	endfunction

	// -------------------------------------------------------------------------
	// monitor: every transfer is seen at the rising edge, before the block's
	// own updates land
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		req_xfer = s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg_write(cfg_index, cfg_data);
			if (req_xfer)
				predict_request(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_event();
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// request driver: falling edge, one queued request at a time, random gaps
	// between transfers
	// -------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!s_axis_tvalid || req_xfer) begin
			if (src_gap != 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				s_axis_tdata  <= pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				src_gap = pick_gap(src_calm);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		if ($urandom_range(63) == 0)
			src_calm = ($urandom_range(2) == 0);
	end

	// event receiver: random back-pressure, with calm stretches
	always @(negedge clk) begin
		if (sink_gap != 0) begin
			sink_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			sink_gap = pick_gap(sink_calm);
		end
		if ($urandom_range(63) == 0)
			sink_calm = ($urandom_range(2) == 0);
	end

	// -------------------------------------------------------------------------
	// sequencing helpers
	// -------------------------------------------------------------------------

	// holds the caller until the sender is empty and every owed event is in;
	// the extra cycles are margin; undefined ops are dropped while idle and owe no events
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || s_axis_tvalid || pin_events_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high so that writes can run back to back
	task automatic write_reg(logic [2:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic set_timing(logic [7:0] pulse, logic [7:0] power_up,
			logic [7:0] cmd_settle, logic [7:0] clr_settle);
		write_reg(3'(REG_ENABLE_PULSE), pulse);
		write_reg(3'(REG_POWER_UP), power_up);
		write_reg(3'(REG_COMMAND_SETTLE), cmd_settle);
		write_reg(3'(REG_CLEAR_SETTLE), clr_settle);
		// stray index: must leave the timing alone
		write_reg(3'($urandom_range(REG_COUNT, MAX_CFG_INDEX)), 8'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed requests; init is rare since it is long
	function automatic logic [23:0] random_req();
		int unsigned r;
		logic [2:0]  op;
		logic [2:0]  row;
		logic [4:0]  column;
		r = $urandom_range(99);
		if (r < 3)
			op = OP_INIT;
		else if (r < 8)
			op = 3'($urandom_range(int'(OP_CLEAR) + 1, MAX_OP_CODE));
		else
			op = 3'($urandom_range(int'(OP_RAW), int'(OP_CLEAR)));
		if ($urandom_range(4) == 0) begin
			row    = 3'($urandom);
			column = 5'($urandom);
		end else begin
			row    = 3'($urandom_range(1, 4));
			column = 5'($urandom_range(1, 20));
		end
		return pack_req(op, 8'($urandom), row, column);
	endfunction

	// timing-sensitive requests first, then random ones
	task automatic run_phase();
		pending_reqs.push_back(pack_req(OP_INIT, 8'd0, 3'd0, 5'd0));
		pending_reqs.push_back(pack_req(OP_CLEAR, 8'd0, 3'd0, 5'd0));
		pending_reqs.push_back(pack_req(OP_CURSOR, 8'd0, 3'($urandom_range(1, 4)),
			5'($urandom_range(1, 20))));
		for (int i = 0; i < PHASE_ITEMS; i++)
			pending_reqs.push_back(random_req());
		wait_idle();
	endtask

	// -------------------------------------------------------------------------
	// test flow
	// -------------------------------------------------------------------------
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		timing_regs.enable_pulse_ms   = 8'd2;
		timing_regs.power_up_ms       = 8'd40;
		timing_regs.command_settle_ms = 8'd1;
		timing_regs.clear_settle_ms   = 8'd10;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed pass on reset timing: every op, byte extremes, each row at
		// both column ends, out-of-range positions, undefined ops
		pending_reqs.push_back(pack_req(OP_INIT, 8'd0, 3'd0, 5'd0));
		pending_reqs.push_back(pack_req(OP_RAW, 8'h00, 3'd0, 5'd0));
		pending_reqs.push_back(pack_req(OP_RAW, 8'hFF, 3'd7, 5'd31));
		pending_reqs.push_back(pack_req(OP_DATA, 8'h00, 3'd0, 5'd0));
		pending_reqs.push_back(pack_req(OP_DATA, 8'hFF, 3'd7, 5'd31));
		pending_reqs.push_back(pack_req(OP_DATA, 8'hA5, 3'd2, 5'd10));
		for (int r = 1; r <= 4; r++) begin
			pending_reqs.push_back(pack_req(OP_CURSOR, 8'd0, 3'(r), 5'd1));
			pending_reqs.push_back(pack_req(OP_CURSOR, 8'hFF, 3'(r), 5'd20));
		end
		pending_reqs.push_back(pack_req(OP_CURSOR, 8'd0, 3'd0, 5'd5));    // row too low
		pending_reqs.push_back(pack_req(OP_CURSOR, 8'd0, 3'd5, 5'd5));    // row too high
		pending_reqs.push_back(pack_req(OP_CURSOR, 8'd0, 3'd7, 5'd31));   // both out
		pending_reqs.push_back(pack_req(OP_CURSOR, 8'd0, 3'd2, 5'd0));    // column too low
		pending_reqs.push_back(pack_req(OP_CURSOR, 8'd0, 3'd3, 5'd21));   // column too high
		pending_reqs.push_back(pack_req(OP_CURSOR, 8'd0, 3'd4, 5'd31));
		pending_reqs.push_back(pack_req(OP_CLEAR, 8'd0, 3'd0, 5'd0));
		for (int op = int'(OP_CLEAR) + 1; op <= MAX_OP_CODE; op++)
			pending_reqs.push_back(pack_req(3'(op), 8'($urandom), 3'($urandom), 5'($urandom)));
		wait_idle();

		// each setting is loaded only once the block has drained, so the
		// sender always pauses for the last owed event first
		set_timing(8'd1, 8'd1, 8'd0, 8'd0);          // pulse and power-up at 1, settles at 0
		run_phase();
		set_timing(8'd255, 8'd255, 8'd255, 8'd255);  // all at maximum, widest wait
		run_phase();
		set_timing(8'd255, 8'd1, 8'd0, 8'd255);
		run_phase();
		repeat (3) begin
			set_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
				8'($urandom), 8'($urandom));
			run_phase();
		end

		if (mismatch_count == 0 && pin_events_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/lcdns_pkg.sv
sv/lcdns_unit.sv
sv/lcdns_seq.sv
sv/char_lcd_nibble_sequencer.sv
dv/tb_char_lcd_nibble_sequencer.sv
